// ===== hdl/tcp_pkg.sv =====
// Shared types and constants for the two-channel thermometer poller.
package tcp_pkg;

    localparam int SCRATCH_BYTES = 9;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE    = 2'd2;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PRES = 2'd1;
    localparam logic [1:0] CMD_BYTE = 2'd2;

    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_SELECT  = 2'd1;
    localparam logic [1:0] REQ_CONVERT = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [1:0] WS_NONE  = 2'd0;
    localparam logic [1:0] WS_ARMED = 2'd1;
    localparam logic [1:0] WS_COUNT = 2'd2;

    typedef enum logic [2:0] {
        PH_MAIN    = 3'd0,
        PH_SELECT  = 3'd1,
        PH_CONVERT = 3'd2,
        PH_READ    = 3'd3,
        PH_IDLE    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        K_TICK = 2'd0,
        K_PRES = 2'd1,
        K_BYTE = 2'd2,
        K_NONE = 2'd3
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic        present;
        logic [7:0]  data_byte;
    } q_item_t;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [15:0] convert_ticks;
        logic [15:0] idle_ticks;
    } cfg_t;

endpackage

// ===== hdl/tcp_front.sv =====
// Front end: takes input transfers, classifies the command and pushes into the queue.
module tcp_front
    import tcp_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] present, [8:1] data_byte, zero fill above
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        q_full,
    output logic        q_push,
    output q_item_t     q_item
);

    item_kind_t kind;

    always_comb begin
        case (s_tuser)
            CMD_TICK: kind = K_TICK;
            CMD_PRES: kind = K_PRES;
            CMD_BYTE: kind = K_BYTE;
            default:  kind = K_NONE;
        endcase
    end

    assign s_tready          = !q_full;
    assign q_push            = s_tvalid && !q_full;
    assign q_item.kind       = kind;
    assign q_item.present    = s_tdata[0];
    assign q_item.data_byte  = s_tdata[8:1];

endmodule

// ===== hdl/tcp_queue.sv =====
// Short queue between front end and sequencer.
module tcp_queue
    import tcp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    q_valid,
    output q_item_t q_head
);

    q_item_t          mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full    = count_reg == (QAW+1)'(QDEPTH);
    assign q_valid = count_reg != '0;
    assign q_head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (QAW+1)'(1);
                2'b01:   count_reg <= count_reg - (QAW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== hdl/tcp_back.sv =====
// Back end: polling sequencer, CRC check, temperature store and result register.
module tcp_back
    import tcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  q_item_t     q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    function automatic logic [7:0] crc_step(input logic [7:0] crc_in, input logic [7:0] b_in);
        logic [7:0] c;
        logic [7:0] b;
        c = crc_in;
        b = b_in;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[0]) begin
                c = (c >> 1) ^ 8'h8C;
            end else begin
                c = c >> 1;
            end
            b = b >> 1;
        end
        return c;
    endfunction

    phase_t       phase_reg, phase_next;
    logic [1:0]   ws_reg, ws_next;
    logic         chan_reg, chan_next;
    logic [15:0]  tick_reg, tick_next;
    logic         pres_reg, pres_next;
    logic [7:0]   crc_reg, crc_next;
    logic [3:0]   bi_reg, bi_next;
    logic [7:0]   low_reg, low_next;
    logic [7:0]   high_reg, high_next;
    logic [15:0]  temp_reg [2];
    logic [15:0]  temp_next [2];

    logic         m_valid_reg;
    logic [23:0]  m_data_reg;

    logic [1:0]   req;
    logic         done;
    logic         valid;
    logic         done_ch;
    logic [15:0]  tick_inc;
    logic [7:0]   crc_stepped;
    logic [3:0]   bi_inc;
    logic         is_tick;
    logic         is_pres;
    logic         is_byte;

    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        phase_next  = phase_reg;
        ws_next     = ws_reg;
        chan_next   = chan_reg;
        tick_next   = tick_reg;
        pres_next   = pres_reg;
        crc_next    = crc_reg;
        bi_next     = bi_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        temp_next   = temp_reg;
        req         = REQ_NONE;
        done        = 1'b0;
        valid       = 1'b0;
        is_tick     = q_head.kind == K_TICK;
        is_pres     = q_head.kind == K_PRES;
        is_byte     = q_head.kind == K_BYTE;
        tick_inc    = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
        crc_stepped = crc_step(crc_reg, q_head.data_byte);
        bi_inc      = bi_reg + 4'd1;

        case (phase_reg)
            PH_MAIN: begin
                if (is_tick) begin
                    chan_next  = 1'b0;
                    phase_next = PH_SELECT;
                    ws_next    = WS_NONE;
                end
            end
            PH_SELECT: begin
                if (is_tick) begin
                    if (ws_reg == WS_NONE) begin
                        req       = REQ_SELECT;
                        tick_next = 16'd0;
                        ws_next   = WS_ARMED;
                    end else begin
                        tick_next = tick_inc;
                    end
                    if (tick_next >= cfg.settle_ticks) begin
                        phase_next = PH_CONVERT;
                        ws_next    = WS_NONE;
                    end
                end
            end
            PH_CONVERT: begin
                if (is_tick && ws_reg == WS_NONE) begin
                    req     = REQ_CONVERT;
                    ws_next = WS_ARMED;
                end else if (is_pres && ws_reg == WS_ARMED) begin
                    pres_next = q_head.present;
                    if (q_head.present) begin
                        tick_next = 16'd0;
                        ws_next   = WS_COUNT;
                    end else begin
                        chan_next  = 1'b1;
                        phase_next = chan_reg ? PH_IDLE : PH_SELECT;
                        ws_next    = WS_NONE;
                    end
                end else if (is_tick && ws_reg == WS_COUNT) begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.convert_ticks) begin
                        req        = REQ_READ;
                        phase_next = PH_READ;
                        ws_next    = WS_ARMED;
                        crc_next   = 8'd0;
                        bi_next    = 4'd0;
                    end
                end
            end
            PH_READ: begin
                if (is_pres && ws_reg == WS_ARMED) begin
                    pres_next = q_head.present;
                    if (q_head.present) begin
                        ws_next = WS_COUNT;
                    end else begin
                        done       = 1'b1;
                        chan_next  = 1'b1;
                        phase_next = chan_reg ? PH_IDLE : PH_SELECT;
                        ws_next    = WS_NONE;
                    end
                end else if (is_byte && ws_reg == WS_COUNT) begin
                    crc_next = crc_stepped;
                    if (bi_reg == 4'd0) begin
                        low_next = q_head.data_byte;
                    end else if (bi_reg == 4'd1) begin
                        high_next = q_head.data_byte;
                    end
                    bi_next = bi_inc;
                    if (bi_inc >= 4'(SCRATCH_BYTES)) begin
                        done = 1'b1;
                        if (crc_stepped == 8'd0) begin
                            valid               = 1'b1;
                            temp_next[chan_reg] = {high_next, low_next};
                        end
                        chan_next  = 1'b1;
                        phase_next = chan_reg ? PH_IDLE : PH_SELECT;
                        ws_next    = WS_NONE;
                    end
                end
            end
            PH_IDLE: begin
                if (is_tick) begin
                    if (ws_reg == WS_NONE) begin
                        tick_next = 16'd0;
                        ws_next   = WS_ARMED;
                    end else begin
                        tick_next = tick_inc;
                    end
                    if (tick_next >= cfg.idle_ticks) begin
                        phase_next = PH_MAIN;
                        ws_next    = WS_NONE;
                    end
                end
            end
            default: begin
                phase_next = PH_MAIN;
                ws_next    = WS_NONE;
            end
        endcase

        done_ch = done ? chan_reg : chan_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MAIN;
            ws_reg      <= WS_NONE;
            chan_reg    <= 1'b0;
            tick_reg    <= 16'd0;
            pres_reg    <= 1'b0;
            crc_reg     <= 8'd0;
            bi_reg      <= 4'd0;
            low_reg     <= 8'd0;
            high_reg    <= 8'd0;
            temp_reg[0] <= 16'd0;
            temp_reg[1] <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg   <= phase_next;
                ws_reg      <= ws_next;
                chan_reg    <= chan_next;
                tick_reg    <= tick_next;
                pres_reg    <= pres_next;
                crc_reg     <= crc_next;
                bi_reg      <= bi_next;
                low_reg     <= low_next;
                high_reg    <= high_next;
                temp_reg[0] <= temp_next[0];
                temp_reg[1] <= temp_next[1];
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= {3'b000, valid, temp_next[done_ch], done, done_ch, req};
        end
    end

    a_valid_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[20] |-> m_data_reg[3])
        else $error("reading_valid without done_res");
    a_done_no_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[3] |-> m_data_reg[1:0] == REQ_NONE)
        else $error("request issued with a finished read");
    a_read_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_READ |-> ws_reg == WS_ARMED || ws_reg == WS_COUNT)
        else $error("read phase without a wait step");
    a_read_issue_enters_read: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && req == REQ_READ |=> phase_reg == PH_READ && bi_reg == 4'd0)
        else $error("read request did not start a scratchpad read");

endmodule

// ===== hdl/two_channel_thermometer_poller.sv =====
// Path: with the queue empty, an input transfer is first written into the queue, then
// popped into the result register, which drives m_tvalid.
// Throughput: one item per cycle, as the sequencer retires one queued item per cycle
// whenever the result register is empty or being taken.
// Queue of 4 entries decouples input and output stalls.
// Reset: aresetn synchronous, active low; sequencer to main phase, queue empty,
// temperatures zero, settle/convert/idle ticks 500/2000/30000.
module two_channel_thermometer_poller
    import tcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [0] present, [8:1] data_byte
    input  logic [1:0]           s_tuser,    // [1:0] command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,    // [1:0] request, [2] bus, [3] done_res,
                                             // [19:4] temperature, [20] reading_valid
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t    cfg_reg;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    q_item_t q_in;
    q_item_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks  <= 16'd500;
            cfg_reg.convert_ticks <= 16'd2000;
            cfg_reg.idle_ticks    <= 16'd30000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SETTLE:  cfg_reg.settle_ticks  <= cfg_data;
                CFG_CONVERT: cfg_reg.convert_ticks <= cfg_data;
                CFG_IDLE:    cfg_reg.idle_ticks    <= cfg_data;
                default:     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    tcp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    tcp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_head    (q_head)
    );

    tcp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/tb.sv =====
// Testbench for the two-channel thermometer poller: directed table, then random sensor sequences.
`timescale 1ns / 1ps

module tb;
    import tcp_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned LIMIT = 200000;
    localparam int LONG_HOLD = 80;

    typedef struct packed {
        logic               reading_valid;
        logic signed [15:0] temperature;
        logic               done_res;
        logic               bus;
        logic [1:0]         request;
    } reading_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SEAL,   // scratchpad byte that closes the CRC to zero
        ROW_CFG     // all three tick registers to zero
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [1:0] cmd;
        logic       pres;
        logic [7:0] data;
        logic       use_table;
        reading_t   want;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;     // [0] present, [8:1] data_byte
    logic [1:0]           s_tuser = '0;     // [1:0] command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;          // [1:0] request, [2] bus, [3] done_res,
                                            // [19:4] temperature, [20] reading_valid
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SETTLE;
    logic [15:0]          cfg_data = '0;

    two_channel_thermometer_poller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sequencer shadow
    logic [15:0] settle_lim = 16'd500;
    logic [15:0] convert_lim = 16'd2000;
    logic [15:0] idle_lim = 16'd30000;
    phase_t      seq_phase = PH_MAIN;
    logic [1:0]  wait_step = WS_NONE;
    logic        cur_chan = 1'b0;
    logic [15:0] tick_cnt = '0;
    logic [7:0]  crc_acc = '0;
    logic [3:0]  byte_pos = '0;
    logic [7:0]  lo_byte = '0;
    logic [7:0]  hi_byte = '0;
    logic [15:0] chan_temp [0:1] = '{16'h0000, 16'h0000};

    logic [7:0]  pad [0:SCRATCH_BYTES-1];
    reading_t    readings_due [$];
    plan_row_t   steps [$];
    reading_t    want, got;

    bit          quiet = 1'b0;
    int          fail_count = 0;
    int          items_sent = 0;
    int          reads_done = 0;
    int          reads_good = 0;
    int          settings_used = 1;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] dallas_crc(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
            c = (c >> 1) ^ ((c[0] ^ b[i]) ? 8'h8C : 8'h00);
        return c;
    endfunction

    function automatic void count_tick();
        if (tick_cnt != 16'hFFFF)
            tick_cnt = tick_cnt + 16'd1;
    endfunction

    function automatic void leave_channel();
        if (cur_chan == 1'b0) begin
            cur_chan = 1'b1;
            seq_phase = PH_SELECT;
        end else begin
            seq_phase = PH_IDLE;
        end
        wait_step = WS_NONE;
    endfunction

    function automatic reading_t poll_step(input logic [1:0] cmd, input logic pres,
                                           input logic [7:0] data);
        reading_t r;
        logic     done_now;
        logic     good;
        logic     chan_out;
        r = '0;
        r.request = REQ_NONE;
        done_now = 1'b0;
        good = 1'b0;
        chan_out = cur_chan;
        case (seq_phase)
            PH_MAIN: begin
                if (cmd == CMD_TICK) begin
                    cur_chan = 1'b0;
                    seq_phase = PH_SELECT;
                    wait_step = WS_NONE;
                end
            end
            PH_SELECT: begin
                if (cmd == CMD_TICK) begin
                    if (wait_step == WS_NONE) begin
                        r.request = REQ_SELECT;
                        tick_cnt = '0;
                        wait_step = WS_ARMED;
                    end else begin
                        count_tick();
                    end
                    if (tick_cnt >= settle_lim) begin
                        seq_phase = PH_CONVERT;
                        wait_step = WS_NONE;
                    end
                end
            end
            PH_CONVERT: begin
                if (cmd == CMD_TICK && wait_step == WS_NONE) begin
                    r.request = REQ_CONVERT;
                    wait_step = WS_ARMED;
                end else if (cmd == CMD_PRES && wait_step == WS_ARMED) begin
                    if (pres) begin
                        tick_cnt = '0;
                        wait_step = WS_COUNT;
                    end else begin
                        leave_channel();
                    end
                end else if (cmd == CMD_TICK && wait_step == WS_COUNT) begin
                    count_tick();
                end
                if (seq_phase == PH_CONVERT && wait_step == WS_COUNT && cmd == CMD_TICK &&
                    tick_cnt >= convert_lim) begin
                    r.request = REQ_READ;
                    seq_phase = PH_READ;
                    wait_step = WS_ARMED;
                    crc_acc = '0;
                    byte_pos = '0;
                end
            end
            PH_READ: begin
                if (cmd == CMD_PRES && wait_step == WS_ARMED) begin
                    if (pres) begin
                        wait_step = WS_COUNT;
                    end else begin
                        done_now = 1'b1;
                        leave_channel();
                    end
                end else if (cmd == CMD_BYTE && wait_step == WS_COUNT) begin
                    crc_acc = dallas_crc(crc_acc, data);
                    if (byte_pos == 4'd0)
                        lo_byte = data;
                    else if (byte_pos == 4'd1)
                        hi_byte = data;
                    byte_pos = byte_pos + 4'd1;
                    if (byte_pos >= SCRATCH_BYTES) begin
                        done_now = 1'b1;
                        if (crc_acc == 8'h00) begin
                            good = 1'b1;
                            chan_temp[cur_chan] = {hi_byte, lo_byte};
                        end
                        leave_channel();
                    end
                end
            end
            PH_IDLE: begin
                if (cmd == CMD_TICK) begin
                    if (wait_step == WS_NONE) begin
                        tick_cnt = '0;
                        wait_step = WS_ARMED;
                    end else begin
                        count_tick();
                    end
                    if (tick_cnt >= idle_lim) begin
                        seq_phase = PH_MAIN;
                        wait_step = WS_NONE;
                    end
                end
            end
            default: begin
                seq_phase = PH_MAIN;
                wait_step = WS_NONE;
            end
        endcase
        if (!done_now)
            chan_out = cur_chan;
        r.bus = chan_out;
        r.done_res = done_now;
        r.temperature = chan_temp[chan_out];
        r.reading_valid = good;
        return r;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [1:0] cmd,
                                    input logic pres, input logic [7:0] data,
                                    input logic use_table, input reading_t want_row);
        plan_row_t row;
        row.kind = kind;
        row.cmd = cmd;
        row.pres = pres;
        row.data = data;
        row.use_table = use_table;
        row.want = want_row;
        steps.push_back(row);
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic pres, input logic [7:0] data,
                             input logic use_table, input reading_t want_row);
        reading_t r;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, data, pres};
        do @(posedge aclk); while (!s_tready);
        r = poll_step(cmd, pres, data);
        readings_due.push_back(use_table ? want_row : r);
        items_sent++;
        if (r.done_res)
            reads_done++;
        if (r.reading_valid)
            reads_good++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SETTLE:  settle_lim = val;
            CFG_CONVERT: convert_lim = val;
            CFG_IDLE:    idle_lim = val;
            default: ;
        endcase
    endtask

    task automatic write_regs(input logic [15:0] settle, input logic [15:0] conv,
                              input logic [15:0] idle);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge aclk);
        put_reg(CFG_SETTLE, settle);
        put_reg(CFG_CONVERT, conv);
        put_reg(CFG_IDLE, idle);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // well-formed sequences with random content, plus some noise
    task automatic pick_item(output logic [1:0] cmd, output logic pres, output logic [7:0] data);
        logic [15:0] word;
        logic [7:0]  seal;
        int          k;
        cmd = CMD_TICK;
        pres = 1'($urandom_range(0, 1));
        data = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
            cmd = 2'($urandom_range(0, 3));
        end else if (wait_step == WS_ARMED && (seq_phase == PH_CONVERT || seq_phase == PH_READ)) begin
            cmd = CMD_PRES;
            pres = ($urandom_range(0, 7) != 0);
        end else if (seq_phase == PH_READ && wait_step == WS_COUNT) begin
            if (byte_pos == 4'd0) begin
                word = 16'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 5))
                        0: word = 16'h0000;
                        1: word = 16'h8000;
                        2: word = 16'h7FFF;
                        3: word = 16'hFFFF;
                        4: word = 16'h0550;
                        default: word = 16'hFC90;
                    endcase
                end
                pad[0] = word[7:0];
                pad[1] = word[15:8];
                for (int i = 2; i < SCRATCH_BYTES - 1; i++)
                    pad[i] = 8'($urandom_range(0, 255));
                seal = 8'h00;
                for (int i = 0; i < SCRATCH_BYTES - 1; i++)
                    seal = dallas_crc(seal, pad[i]);
                pad[SCRATCH_BYTES-1] = seal;
                if ($urandom_range(0, 5) == 0) begin
                    k = $urandom_range(0, SCRATCH_BYTES - 1);
                    pad[k] = pad[k] ^ (8'd1 << $urandom_range(0, 7));
                end
            end
            cmd = CMD_BYTE;
            data = pad[byte_pos];
        end
    endtask

    // receiver: random stall bursts, one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[20:0];
            if (readings_due.size() == 0) begin
                $error("unexpected result transfer: %h", m_tdata);
                fail_count++;
            end else begin
                want = readings_due.pop_front();
                if (got.request !== want.request) begin
                    $error("request: expected %0d, got %0d", want.request, got.request);
                    fail_count++;
                end
                if (got.bus !== want.bus) begin
                    $error("bus: expected %0d, got %0d", want.bus, got.bus);
                    fail_count++;
                end
                if (got.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                    fail_count++;
                end
                if (got.temperature !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d",
                           $signed(want.temperature), $signed(got.temperature));
                    fail_count++;
                end
                if (got.reading_valid !== want.reading_valid) begin
                    $error("reading_valid: expected %0d, got %0d",
                           want.reading_valid, got.reading_valid);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [63:0] sample_pad;
        logic [1:0]  c;
        logic        pr;
        logic [7:0]  d;
        int          n;
        reading_t    none_r;

        none_r = {1'b0, 16'h0000, 1'b0, 1'b0, REQ_NONE};
        sample_pad = 64'h01FF_5AA5_00FF_8000;

        // reset config: select request, then ignored items
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b1, none_r);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b1, {1'b0, 16'h0000, 1'b0, 1'b0, REQ_SELECT});
        add_row(ROW_ITEM, CMD_PRES, 1'b1, 8'hFF, 1'b1, none_r);
        add_row(ROW_ITEM, CMD_UNUSED, 1'b1, 8'hFF, 1'b1, none_r);
        add_row(ROW_CFG, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        // zero waits: good read of the most negative word on the indoor bus
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b1, {1'b0, 16'h0000, 1'b0, 1'b0, REQ_CONVERT});
        add_row(ROW_ITEM, CMD_PRES, 1'b1, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b1, {1'b0, 16'h0000, 1'b0, 1'b0, REQ_READ});
        add_row(ROW_ITEM, CMD_PRES, 1'b1, 8'h00, 1'b0, '0);
        for (int i = 0; i < SCRATCH_BYTES - 1; i++)
            add_row(ROW_ITEM, CMD_BYTE, 1'b0, sample_pad[(i % 8) * 8 +: 8], 1'b0, '0);
        add_row(ROW_SEAL, CMD_BYTE, 1'b0, 8'h00, 1'b1, {1'b1, 16'h8000, 1'b1, 1'b0, REQ_NONE});
        // outdoor sensor gone at read
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_PRES, 1'b1, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_PRES, 1'b0, 8'h00, 1'b1, {1'b0, 16'h0000, 1'b1, 1'b1, REQ_NONE});
        // idle, next round, indoor sensor gone at convert
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_TICK, 1'b0, 8'h00, 1'b0, '0);
        add_row(ROW_ITEM, CMD_PRES, 1'b0, 8'h00, 1'b0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < steps.size(); i++) begin
            case (steps[i].kind)
                ROW_CFG:  write_regs(16'd0, 16'd0, 16'd0);
                ROW_SEAL: send_item(CMD_BYTE, 1'b0, crc_acc, steps[i].use_table, steps[i].want);
                default:  send_item(steps[i].cmd, steps[i].pres, steps[i].data,
                                    steps[i].use_table, steps[i].want);
            endcase
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_regs(16'd1, 16'd2, 16'd0);
                1: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_regs(16'd0, 16'd0, 16'd0);
                3: write_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                              16'($urandom_range(0, 4)));
                4: write_regs(16'd3, 16'd1, 16'd2);
                default: begin
                    write_regs(16'd0, 16'd1, 16'd0);
                    quiet = 1'b1;
                end
            endcase
            n = (p == 1) ? 40 : 200;
            if (p == 2)
                holds_asked++;
            repeat (n) begin
                pick_item(c, pr, d);
                send_item(c, pr, d, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d items under %0d tick settings, with idling and one long output hold.",
                 items_sent, settings_used);
        $display("Reads finished: %0d, of which %0d passed the CRC.", reads_done, reads_good);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
